// ----- rtl/acfs_pkg.sv -----
// acfs_pkg: shared widths, codes, CORDIC table and inter-module structs
// for the antisymmetric coupling Fourier sum block. No dependencies.
package acfs_pkg;

  localparam int unsigned WAVE_W     = 16;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned J_W        = 24;
  localparam int unsigned OFS_W      = 48;
  localparam int unsigned COMP_W     = 16;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned D_W        = J_W + 1;
  localparam int unsigned TRIG_W     = 18;
  localparam int unsigned PROD_W     = D_W + TRIG_W;
  localparam int unsigned TERM_W     = PROD_W + 1 - 16;
  localparam int unsigned ANG_W      = 32;
  localparam int unsigned FRAC_PH    = 22;
  localparam int unsigned CV_W       = 33;
  localparam int unsigned CZ_W       = 33;
  localparam int unsigned ROT_MAX    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PCNT_W     = 3;

  localparam logic [PCNT_W-1:0] PHASE_TERMS = 3'd6;

  localparam logic signed [CV_W-1:0] CORDIC_K = 33'sh026DD3B6A;

  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_X = 3'd0,
    REG_WAVE_Y = 3'd1,
    REG_WAVE_Z = 3'd2,
    REG_NU     = 3'd3,
    REG_MU     = 3'd4
  } cfg_reg_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PHASE = 6'b000010,
    S_ROT   = 6'b000100,
    S_MREAL = 6'b001000,
    S_MIMAG = 6'b010000,
    S_EMIT  = 6'b100000
  } seq_state_e;

  typedef struct packed {
    logic             start;
    logic [ANG_W-1:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } cor_rsp_t;

  // atan(2^-i) in turns, scaled by 2^32
  function automatic logic [ANG_W-1:0] atan_turns(input logic [4:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/acfs_if.sv -----
// acfs_if: valid/ready channel interfaces for entry, result and config beats.
// Depends on acfs_pkg.
interface acfs_in_if import acfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [AXIS_W-1:0]       direction;
  logic signed [J_W-1:0]   j_xy;
  logic signed [J_W-1:0]   j_yx;
  logic signed [J_W-1:0]   j_xz;
  logic signed [J_W-1:0]   j_zx;
  logic signed [J_W-1:0]   j_yz;
  logic signed [J_W-1:0]   j_zy;
  logic [OFS_W-1:0]        offset_ij;
  logic [OFS_W-1:0]        offset_ki;
  logic                    last_entry;

  modport source (output valid, direction, j_xy, j_yx, j_xz, j_zx, j_yz, j_zy,
                  offset_ij, offset_ki, last_entry, input ready);
  modport sink   (input valid, direction, j_xy, j_yx, j_xz, j_zx, j_yz, j_zy,
                  offset_ij, offset_ki, last_entry, output ready);
endinterface

interface acfs_out_if import acfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_real;
  logic signed [SUM_W-1:0] sum_imag;
  logic                    overflowed;

  modport source (output valid, sum_real, sum_imag, overflowed, input ready);
  modport sink   (input valid, sum_real, sum_imag, overflowed, output ready);
endinterface

interface acfs_cfg_if import acfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/acfs_mul.sv -----
// acfs_mul: shared signed multiplier with registered product.
// Depends on acfs_pkg.
module acfs_mul import acfs_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [D_W-1:0]    a_i,
  input  logic signed [TRIG_W-1:0] b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/acfs_cordic.sv -----
// acfs_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Angle in turns scaled by 2^32. Depends on acfs_pkg.
module acfs_cordic import acfs_pkg::*; #(
  parameter int unsigned ROT = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cor_req_t req_i,
  output cor_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(ROT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROT - 1);
  localparam logic signed [CZ_W-1:0] QTR  = 33'sh040000000;
  localparam logic signed [CZ_W-1:0] NQTR = -33'sh040000000;
  localparam logic signed [CZ_W-1:0] HALF = 33'sh080000000;
  localparam logic signed [CV_W-1:0] RND  = CV_W'(1 << 13);

  logic signed [CV_W-1:0] x_q, y_q;
  logic signed [CZ_W-1:0] z_q;
  logic                   neg_q, busy_q, done_q;
  logic [CNT_W-1:0]       cnt_q;

  logic signed [CZ_W-1:0] z_in, z_fold, at;
  logic                   neg_in;
  logic signed [CV_W-1:0] dx, dy, xr, yr;

  always_comb begin
    z_in   = $signed({req_i.angle[ANG_W-1], req_i.angle});
    z_fold = z_in;
    neg_in = 1'b0;
    if (z_in > QTR) begin
      z_fold = z_in - HALF;
      neg_in = 1'b1;
    end else if (z_in < NQTR) begin
      z_fold = z_in + HALF;
      neg_in = 1'b1;
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = $signed({1'b0, atan_turns(5'(cnt_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_LAST);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= CORDIC_K;
      y_q   <= '0;
      z_q   <= z_fold;
      neg_q <= neg_in;
    end else if (busy_q) begin
      if (!z_q[CZ_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  // round Q2.30 to Q1.16
  assign xr = (x_q + RND) >>> 14;
  assign yr = (y_q + RND) >>> 14;

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = neg_q ? -TRIG_W'(xr) : TRIG_W'(xr);
  assign rsp_o.sin_v = neg_q ? -TRIG_W'(yr) : TRIG_W'(yr);

endmodule

// ----- rtl/antisymmetric_coupling_fourier_sum.sv -----
// antisymmetric_coupling_fourier_sum: top level, sequencer, config registers
// and saturating accumulators. Depends on acfs_pkg, acfs_if, acfs_mul, acfs_cordic.
//
//   channel  dir   modport          beat
//   in_i     in    acfs_in_if.sink  one coupling entry
//   out_o    out   acfs_out_if.source saturated complex sum on last entry
//   cfg_i    in    acfs_cfg_if.sink register index + data, always ready
//
// Matching entry: accept, phase multiply (S_PHASE), CORDIC rotation wait (S_ROT,
// one step per cycle) and real/imag multiply-accumulate (S_MREAL, S_MIMAG); the
// phase and accumulate steps share the multiplier. A skipped entry stays idle.
// The last entry then goes through S_EMIT to load the output register; it waits there
// while an earlier result is still unread. in_i.ready is high only when idle.
// Reset clears config registers, accumulators and control; no clearing pass.
module antisymmetric_coupling_fourier_sum import acfs_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned PHASE_BITS   = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  acfs_in_if.sink    in_i,
  acfs_out_if.source out_o,
  acfs_cfg_if.sink   cfg_i
);

  localparam int unsigned ROT = (CORDIC_STEPS > ROT_MAX) ? ROT_MAX : CORDIC_STEPS;
  localparam logic [ANG_W-1:0] ANG_MASK =
    ~((ANG_W'(1) << (ANG_W - PHASE_BITS)) - ANG_W'(1));
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [PROD_W:0]  TRM_RND = (PROD_W+1)'(1 << 15);

  seq_state_e state_q, state_d;

  logic signed [WAVE_W-1:0] wave_x_q, wave_y_q, wave_z_q;
  logic [AXIS_W-1:0]        nu_q, mu_q;

  logic signed [D_W-1:0]    d_q, d_in;
  logic [OFS_W-1:0]         ofs_ij_q, ofs_ki_q;
  logic                     last_q;
  logic [PCNT_W-1:0]        cnt_q;
  logic [FRAC_PH-1:0]       phase_q, phase_sum;

  logic signed [ACC_W-1:0]  acc_real_q, acc_imag_q;
  logic                     sat_flag_q;

  logic                     out_valid_q, out_ovf_q;
  logic signed [SUM_W-1:0]  out_real_q, out_imag_q;

  logic                     in_acc, work, out_load;
  logic signed [D_W-1:0]    mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PCNT_W-1:0]        comp_sel;
  logic [OFS_W-1:0]         ofs_sel;
  logic signed [COMP_W-1:0] r_comp;
  logic signed [WAVE_W-1:0] k_comp;

  logic signed [PROD_W:0]   trm_full;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_sel, acc_new;
  logic signed [ACC_W:0]    acc_sum;
  logic                     acc_ovf;

  logic signed [SUM_W-1:0]  re_sat, im_sat;
  logic                     re_ovf, im_ovf;

  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  // ---------------- config ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_x_q <= '0;
      wave_y_q <= '0;
      wave_z_q <= '0;
      nu_q     <= AXIS_X;
      mu_q     <= AXIS_X;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_WAVE_X: wave_x_q <= $signed(cfg_i.data[WAVE_W-1:0]);
        REG_WAVE_Y: wave_y_q <= $signed(cfg_i.data[WAVE_W-1:0]);
        REG_WAVE_Z: wave_z_q <= $signed(cfg_i.data[WAVE_W-1:0]);
        REG_NU:     nu_q     <= cfg_i.data[AXIS_W-1:0];
        REG_MU:     mu_q     <= cfg_i.data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- entry decode ----------------
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign work       = (in_i.direction == mu_q) && (nu_q != AXIS_NONE);

  always_comb begin
    case (nu_q)
      AXIS_X:  d_in = D_W'(in_i.j_yz) - D_W'(in_i.j_zy);
      AXIS_Y:  d_in = D_W'(in_i.j_xz) - D_W'(in_i.j_zx);
      AXIS_Z:  d_in = D_W'(in_i.j_xy) - D_W'(in_i.j_yx);
      default: d_in = '0;
    endcase
  end

  // ---------------- shared multiplier operands ----------------
  always_comb begin
    if (cnt_q < 3'd3) begin
      comp_sel = cnt_q;
      ofs_sel  = ofs_ij_q;
    end else begin
      comp_sel = cnt_q - 3'd3;
      ofs_sel  = ofs_ki_q;
    end
    case (comp_sel)
      3'd0: begin
        k_comp = wave_x_q;
        r_comp = $signed(ofs_sel[COMP_W-1:0]);
      end
      3'd1: begin
        k_comp = wave_y_q;
        r_comp = $signed(ofs_sel[2*COMP_W-1:COMP_W]);
      end
      default: begin
        k_comp = wave_z_q;
        r_comp = $signed(ofs_sel[3*COMP_W-1:2*COMP_W]);
      end
    endcase
  end

  always_comb begin
    mul_a = d_q;
    mul_b = cor_rsp.cos_v;
    case (state_q)
      S_PHASE: begin
        mul_a = D_W'(k_comp);
        mul_b = TRIG_W'(r_comp);
      end
      S_MREAL: mul_b = cor_rsp.sin_v;
      default: ;
    endcase
  end

  acfs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // phase only needs the fractional turn, so it wraps at 22 bits
  assign phase_sum     = phase_q + prod[FRAC_PH-1:0];
  assign cor_req.start = (state_q == S_PHASE) && (cnt_q == PHASE_TERMS);
  assign cor_req.angle = {phase_sum, (ANG_W-FRAC_PH)'(0)} & ANG_MASK;

  acfs_cordic #(
    .ROT (ROT)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  // ---------------- accumulate ----------------
  assign trm_full = ($signed({prod[PROD_W-1], prod}) + TRM_RND) >>> 16;
  assign term     = TERM_W'(trm_full);
  assign acc_sel  = (state_q == S_MREAL) ? acc_real_q : acc_imag_q;
  assign acc_sum  = $signed({acc_sel[ACC_W-1], acc_sel}) + (ACC_W+1)'(term);
  assign acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];

  always_comb begin
    if (!acc_ovf) begin
      acc_new = ACC_W'(acc_sum);
    end else if (acc_sum[ACC_W]) begin
      acc_new = ACC_MIN;
    end else begin
      acc_new = ACC_MAX;
    end
  end

  function automatic logic signed [SUM_W:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [SUM_W:0] r;
    if (v > ACC_W'(SUM_MAX)) begin
      r = {1'b1, SUM_MAX};
    end else if (v < ACC_W'(SUM_MIN)) begin
      r = {1'b1, SUM_MIN};
    end else begin
      r = {1'b0, SUM_W'(v)};
    end
    return r;
  endfunction

  assign {re_ovf, re_sat} = sat_out(acc_real_q);
  assign {im_ovf, im_sat} = sat_out(acc_imag_q);

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (work) begin
            state_d = S_PHASE;
          end else if (in_i.last_entry) begin
            state_d = S_EMIT;
          end
        end
      end
      S_PHASE: begin
        if (cnt_q == PHASE_TERMS) begin
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        if (cor_rsp.done) begin
          state_d = S_MREAL;
        end
      end
      S_MREAL: state_d = S_MIMAG;
      S_MIMAG: state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      acc_real_q  <= '0;
      acc_imag_q  <= '0;
      sat_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q  <= '0;
        last_q <= in_i.last_entry;
      end else if (state_q == S_PHASE) begin
        cnt_q <= cnt_q + PCNT_W'(1);
      end
      if (state_q == S_MREAL) begin
        acc_real_q <= acc_new;
        sat_flag_q <= sat_flag_q | acc_ovf;
      end
      if (state_q == S_MIMAG) begin
        acc_imag_q <= acc_new;
        sat_flag_q <= sat_flag_q | acc_ovf;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        acc_real_q  <= '0;
        acc_imag_q  <= '0;
        sat_flag_q  <= 1'b0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      d_q      <= d_in;
      ofs_ij_q <= in_i.offset_ij;
      ofs_ki_q <= in_i.offset_ki;
      phase_q  <= '0;
    end else if ((state_q == S_PHASE) && (cnt_q != '0)) begin
      phase_q <= phase_sum;
    end
    if (out_load) begin
      out_real_q <= re_sat;
      out_imag_q <= im_sat;
      out_ovf_q  <= sat_flag_q | re_ovf | im_ovf;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sum_real   = out_real_q;
  assign out_o.sum_imag   = out_imag_q;
  assign out_o.overflowed = out_ovf_q;

  // ---------------- assertions ----------------
  a_cor_done_in_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_rsp.done |-> (state_q == S_ROT))
    else $error("CORDIC finished outside rotation wait");

  a_skip_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !work && !in_i.last_entry) |=> (state_q == S_IDLE))
    else $error("skipped entry left the idle state");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (acc_real_q == '0) && (acc_imag_q == '0) && !sat_flag_q && out_valid_q)
    else $error("accumulators not cleared after result load");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside emit");

endmodule

// ----- dv/tb_antisymmetric_coupling_fourier_sum.sv -----
`timescale 1ns / 1ps
// Testbench for antisymmetric_coupling_fourier_sum: directed table plus random coupling lists,
// each result checked against an in-bench fixed-point model of the CORDIC Fourier sum.
// Depends on acfs_pkg, the acfs_*_if interfaces and the RTL top level.
module tb_antisymmetric_coupling_fourier_sum;
  import acfs_pkg::*;

  localparam int CORDIC_STEPS  = 16;
  localparam int PHASE_BITS    = 16;
  localparam int ROT_STEPS     = (CORDIC_STEPS > ROT_MAX) ? ROT_MAX : CORDIC_STEPS;
  localparam int SETTLE_CYCLES = 2 * (ROT_STEPS + 12);
  localparam int ITEM_GOAL     = 750;
  localparam int CALM_TAIL     = 100;
  localparam longint RUN_LIMIT_NS = 64'd3_000_000;

  localparam logic signed [J_W-1:0] J_MAX    = 24'sh7FFFFF;
  localparam logic signed [J_W-1:0] J_MIN    = 24'sh800000;
  localparam logic [OFS_W-1:0]      OFS_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [OFS_W-1:0]      OFS_MAXS = 48'h7FFF_7FFF_7FFF;
  localparam logic [OFS_W-1:0]      OFS_MINS = 48'h8000_8000_8000;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE = REG_MU + 1;
  localparam logic [CFG_IDX_W-1:0]  REG_TOP   = '1;
  localparam longint ROT_START = 64'h26DD3B6A;
  localparam longint ATAN_LUT [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic [AXIS_W-1:0]     direction;
    logic signed [J_W-1:0] j_xy;
    logic signed [J_W-1:0] j_yx;
    logic signed [J_W-1:0] j_xz;
    logic signed [J_W-1:0] j_zx;
    logic signed [J_W-1:0] j_yz;
    logic signed [J_W-1:0] j_zy;
    logic [OFS_W-1:0]      offset_ij;
    logic [OFS_W-1:0]      offset_ki;
    logic                  last_entry;
  } entry_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    ovf;
  } sum_t;

  typedef enum logic {ROW_ENTRY, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    entry_t                ent;
    bit                    zero_sum;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  acfs_in_if  entry_if ();
  acfs_out_if sum_if ();
  acfs_cfg_if reg_if ();

  antisymmetric_coupling_fourier_sum #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .PHASE_BITS  (PHASE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (entry_if),
    .out_o (sum_if),
    .cfg_i (reg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic signed [WAVE_W-1:0] k_x = '0, k_y = '0, k_z = '0;
  logic [AXIS_W-1:0]        nu_sel = AXIS_X, mu_sel = AXIS_X;
  longint                   acc_re = 0, acc_im = 0;
  bit                       sat_seen = 1'b0;

  sum_t sums_due[$];
  int   fail_count = 0;
  int   items_sent = 0;
  bit   calm = 1'b0;

  function automatic longint clamp(input longint v, input int w, inout bit flag);
    longint lim;
    lim = longint'(1) <<< (w - 1);
    if (v > lim - 1) begin
      flag = 1'b1;
      return lim - 1;
    end
    if (v < -lim) begin
      flag = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  function automatic longint k_dot(input logic [OFS_W-1:0] r);
    return longint'(k_x) * longint'($signed(r[15:0])) +
           longint'(k_y) * longint'($signed(r[31:16])) +
           longint'(k_z) * longint'($signed(r[47:32]));
  endfunction

  function automatic void rotate_turns(input logic [ANG_W-1:0] ang,
                                       output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ang));
    x = ROT_START;
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_LUT[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_LUT[i];
      end
    end
    x = (x + 64'sd8192) >>> 14;
    y = (y + 64'sd8192) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic bit accumulate_coupling(input entry_t e, output sum_t res);
    longint d, phase, c, s, re, im;
    logic [63:0] turns;
    logic [ANG_W-1:0] ang;
    bit f;
    res = '0;
    if (e.direction == mu_sel && nu_sel != AXIS_NONE) begin
      case (nu_sel)
        AXIS_X:  d = longint'(e.j_yz) - longint'(e.j_zy);
        AXIS_Y:  d = longint'(e.j_xz) - longint'(e.j_zx);
        default: d = longint'(e.j_xy) - longint'(e.j_yx);
      endcase
      phase = k_dot(e.offset_ij) + k_dot(e.offset_ki);
      turns = phase;
      if (PHASE_BITS <= FRAC_PH) turns = turns >> (FRAC_PH - PHASE_BITS);
      else turns = turns << (PHASE_BITS - FRAC_PH);
      ang = turns[ANG_W-1:0] << (ANG_W - PHASE_BITS);
      rotate_turns(ang, c, s);
      acc_re = clamp(acc_re + ((d * c + 64'sd32768) >>> 16), ACC_W, sat_seen);
      acc_im = clamp(acc_im + ((d * s + 64'sd32768) >>> 16), ACC_W, sat_seen);
    end
    if (e.last_entry) begin
      f = sat_seen;
      re = clamp(acc_re, SUM_W, f);
      im = clamp(acc_im, SUM_W, f);
      res.re = re[SUM_W-1:0];
      res.im = im[SUM_W-1:0];
      res.ovf = f;
      acc_re = 0;
      acc_im = 0;
      sat_seen = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic row_t mk_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{kind: ROW_WRITE, reg_idx: idx, reg_val: val, ent: '0, zero_sum: 1'b0};
    return r;
  endfunction

  // jp lands on j_xy/j_xz/j_yz, jn on j_yx/j_zx/j_zy
  function automatic row_t mk_entry(input logic [AXIS_W-1:0] dir,
                                    input logic signed [J_W-1:0] jp,
                                    input logic signed [J_W-1:0] jn,
                                    input logic [OFS_W-1:0] oij,
                                    input logic [OFS_W-1:0] oki,
                                    input logic last, input bit zero_sum);
    row_t r;
    r = '{kind: ROW_ENTRY, reg_idx: '0, reg_val: '0, ent: '0, zero_sum: zero_sum};
    r.ent.direction = dir;
    r.ent.j_xy = jp;
    r.ent.j_xz = jp;
    r.ent.j_yz = jp;
    r.ent.j_yx = jn;
    r.ent.j_zx = jn;
    r.ent.j_zy = jn;
    r.ent.offset_ij = oij;
    r.ent.offset_ki = oki;
    r.ent.last_entry = last;
    return r;
  endfunction

  function automatic logic signed [J_W-1:0] pick_j();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? J_MAX : J_MIN;
    return J_W'($urandom);
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0: return OFS_MAXS;
      1: return OFS_MINS;
      2: return '0;
      default: return OFS_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val;
    do @(posedge clk_i); while (!reg_if.ready);
    case (idx)
      REG_WAVE_X: k_x = val;
      REG_WAVE_Y: k_y = val;
      REG_WAVE_Z: k_z = val;
      REG_NU:     nu_sel = val[AXIS_W-1:0];
      REG_MU:     mu_sel = val[AXIS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_entry(input entry_t e, input bit zero_sum);
    sum_t r;
    reg_if.valid <= 1'b0;
    if (!calm && $urandom_range(0, 4) == 0) begin
      entry_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    entry_if.valid      <= 1'b1;
    entry_if.direction  <= e.direction;
    entry_if.j_xy       <= e.j_xy;
    entry_if.j_yx       <= e.j_yx;
    entry_if.j_xz       <= e.j_xz;
    entry_if.j_zx       <= e.j_zx;
    entry_if.j_yz       <= e.j_yz;
    entry_if.j_zy       <= e.j_zy;
    entry_if.offset_ij  <= e.offset_ij;
    entry_if.offset_ki  <= e.offset_ki;
    entry_if.last_entry <= e.last_entry;
    do @(posedge clk_i); while (!entry_if.ready);
    if (accumulate_coupling(e, r)) begin
      if (zero_sum) sums_due.push_back('0);
      else sums_due.push_back(r);
    end
    items_sent++;
  endtask

  // block idle: nothing owed and the last skipped or pending entry flushed
  task automatic settle();
    entry_if.valid <= 1'b0;
    reg_if.valid   <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic flag_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  initial begin : sum_monitor
    sum_t want;
    int stall_left;
    stall_left = 0;
    sum_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && sum_if.valid && sum_if.ready) begin
        if (sums_due.size() == 0) begin
          $display("%0t: unexpected sum beat, real %0d imag %0d ovf %0d", $time,
                   sum_if.sum_real, sum_if.sum_imag, sum_if.overflowed);
          fail_count++;
        end else begin
          want = sums_due.pop_front();
          flag_field("sum_real", longint'(want.re), longint'(sum_if.sum_real));
          flag_field("sum_imag", longint'(want.im), longint'(sum_if.sum_imag));
          flag_field("overflowed", longint'(want.ovf), longint'(sum_if.overflowed));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        sum_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        sum_if.ready <= 1'b0;
      end else begin
        sum_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    row_t plan[$];
    entry_t e;
    int len;
    bit broken;
    logic [CFG_DATA_W-1:0] v;
    logic [AXIS_W-1:0] code;

    rst_ni = 1'b0;
    entry_if.valid <= 1'b0;
    entry_if.direction <= '0;
    entry_if.j_xy <= '0;
    entry_if.j_yx <= '0;
    entry_if.j_xz <= '0;
    entry_if.j_zx <= '0;
    entry_if.j_yz <= '0;
    entry_if.j_zy <= '0;
    entry_if.offset_ij <= '0;
    entry_if.offset_ki <= '0;
    entry_if.last_entry <= 1'b0;
    reg_if.valid <= 1'b0;
    reg_if.index <= '0;
    reg_if.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: k = 0, nu = mu = x
    plan.push_back(mk_entry(AXIS_X, '0, '0, '0, '0, 1'b1, 1'b1));
    plan.push_back(mk_entry(AXIS_Y, J_MAX, J_MIN, OFS_ONES, OFS_ONES, 1'b1, 1'b1));
    plan.push_back(mk_entry(AXIS_X, J_MAX, J_MIN, OFS_ONES, OFS_MAXS, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_X, J_MIN, J_MAX, OFS_MINS, '0, 1'b1, 1'b0));
    plan.push_back(mk_write(REG_WAVE_X, 16'h7FFF));
    plan.push_back(mk_write(REG_WAVE_Y, 16'h8000));
    plan.push_back(mk_write(REG_WAVE_Z, 16'h7FFF));
    plan.push_back(mk_write(REG_NU, AXIS_Y));
    plan.push_back(mk_write(REG_MU, AXIS_Z));
    plan.push_back(mk_entry(AXIS_Z, J_MAX, J_MIN, OFS_MAXS, OFS_MINS, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_Z, J_MAX, J_MIN, OFS_MINS, OFS_MINS, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_Z, J_MIN, J_MAX, OFS_ONES, OFS_MAXS, 1'b1, 1'b0));
    plan.push_back(mk_write(REG_WAVE_X, 16'h8000));
    plan.push_back(mk_write(REG_NU, AXIS_Z));
    plan.push_back(mk_write(REG_MU, AXIS_Y));
    plan.push_back(mk_entry(AXIS_Y, J_MAX, J_MIN, OFS_MAXS, OFS_ONES, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_Y, J_MIN, J_MIN, OFS_MINS, OFS_MAXS, 1'b1, 1'b0));
    // nu unused: nothing accumulates
    plan.push_back(mk_write(REG_NU, AXIS_NONE));
    plan.push_back(mk_write(REG_MU, AXIS_NONE));
    plan.push_back(mk_entry(AXIS_NONE, J_MAX, J_MIN, OFS_MAXS, OFS_MAXS, 1'b1, 1'b1));
    // raw code 3 matches; write to an unmapped index must be ignored
    plan.push_back(mk_write(REG_NU, AXIS_X));
    plan.push_back(mk_write(REG_TOP, 16'hFFFF));
    plan.push_back(mk_entry(AXIS_NONE, J_MAX, J_MIN, OFS_MAXS, OFS_MINS, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_X, J_MAX, J_MIN, '0, '0, 1'b1, 1'b0));
    // quarter-turn steps and finer angles across the quadrant folds
    plan.push_back(mk_write(REG_WAVE_X, 16'h1000));
    plan.push_back(mk_write(REG_WAVE_Y, 16'h0000));
    plan.push_back(mk_write(REG_WAVE_Z, 16'h0000));
    plan.push_back(mk_write(REG_MU, AXIS_X));
    plan.push_back(mk_entry(AXIS_X, J_MAX, '0, 48'h0100, '0, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_X, J_MAX, '0, 48'h0200, '0, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_X, J_MAX, '0, 48'h0300, '0, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_X, J_MAX, '0, 48'h0080, '0, 1'b0, 1'b0));
    plan.push_back(mk_entry(AXIS_X, J_MIN, '0, 48'h0040, 48'h0000_0000_FF00, 1'b1, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind != ROW_WRITE) settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_entry(plan[i].ent, plan[i].zero_sum);
      end
    end

    while (items_sent < ITEM_GOAL) begin
      calm = (items_sent >= ITEM_GOAL - CALM_TAIL);
      if ($urandom_range(0, 2) == 0) begin
        settle();
        for (int r = REG_WAVE_X; r <= REG_MU; r++) begin
          if ($urandom_range(0, 1) == 1) begin
            if (r <= REG_WAVE_Z) begin
              case ($urandom_range(0, 4))
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                2: v = '0;
                default: v = $urandom;
              endcase
            end else begin
              code = ($urandom_range(0, 7) == 0) ? AXIS_NONE : AXIS_W'($urandom_range(0, 2));
              v = $urandom;
              v[AXIS_W-1:0] = code;
            end
            write_reg(CFG_IDX_W'(r), v);
          end
        end
        if ($urandom_range(0, 5) == 0) write_reg(CFG_IDX_W'($urandom_range(REG_SPARE, REG_TOP)),
                                                 $urandom);
      end
      len = $urandom_range(1, 12);
      broken = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        e.direction  = ($urandom_range(0, 4) == 0) ? AXIS_W'($urandom_range(0, 3)) : mu_sel;
        e.j_xy       = pick_j();
        e.j_yx       = pick_j();
        e.j_xz       = pick_j();
        e.j_zx       = pick_j();
        e.j_yz       = pick_j();
        e.j_zy       = pick_j();
        e.offset_ij  = pick_offset();
        e.offset_ki  = pick_offset();
        e.last_entry = broken ? ($urandom_range(0, 3) == 0) : (i == len - 1);
        send_entry(e, 1'b0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/acfs_pkg.sv
rtl/acfs_if.sv
rtl/acfs_mul.sv
rtl/acfs_cordic.sv
rtl/antisymmetric_coupling_fourier_sum.sv
dv/tb_antisymmetric_coupling_fourier_sum.sv
